// ===== hw/rtl/pumap_pkg.sv =====
package pumap_pkg;

  // field and register widths
  localparam int FRAC_BITS  = 8;
  localparam int ANGLE_BITS = 16;
  localparam int ROW_W      = 12;
  localparam int COL_W      = 13;
  localparam int REG_W      = 12;
  localparam int WID_W      = 13;
  localparam int OUT_W      = 22;
  localparam int TRIG_W     = 16;
  localparam int AW         = 5;

  // cordic datapath
  localparam int CORDIC_STEPS = 30;
  localparam int CW           = 33;
  localparam int ZW           = 32;
  localparam logic signed [CW-1:0] CORDIC_X0 = 33'sd652032874;

  // angle divider: column scaled to a turn
  localparam int ADIV_STAGES = COL_W + ANGLE_BITS;
  localparam int ANG_LAT     = ADIV_STAGES + CORDIC_STEPS + 1;

  // radius divider
  localparam int PROD_W  = 2 * (REG_W + 1);
  localparam int MAG_W   = ROW_W + REG_W;
  localparam int RNUM_W  = MAG_W + FRAC_BITS;
  localparam int RAD_W   = RNUM_W + 2;
  localparam int RAD_LAT = RNUM_W + 4;
  localparam int RAD_DLY = ANG_LAT - RAD_LAT;

  // output arithmetic
  localparam int MUL_W     = RAD_W + TRIG_W;
  localparam int OFS_W     = MUL_W - 14;
  localparam int SUM_W     = OFS_W + 1;
  localparam int TOTAL_LAT = ANG_LAT + 3;
  localparam int OUT_MAX   = 2097151;
  localparam int OUT_MIN   = -2097152;

  // register indexes on the configuration port
  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_INNER    = 3'd2;
  localparam logic [2:0] REG_OUTER    = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    case (i)
      0:  atan_turn = 32'sh20000000;
      1:  atan_turn = 32'sh12E4051E;
      2:  atan_turn = 32'sh09FB385B;
      3:  atan_turn = 32'sh051111D4;
      4:  atan_turn = 32'sh028B0D43;
      5:  atan_turn = 32'sh0145D7E1;
      6:  atan_turn = 32'sh00A2F61E;
      7:  atan_turn = 32'sh00517C55;
      8:  atan_turn = 32'sh0028BE53;
      9:  atan_turn = 32'sh00145F2F;
      10: atan_turn = 32'sh000A2F98;
      11: atan_turn = 32'sh000517CC;
      12: atan_turn = 32'sh00028BE6;
      13: atan_turn = 32'sh000145F3;
      14: atan_turn = 32'sh0000A2FA;
      15: atan_turn = 32'sh0000517D;
      16: atan_turn = 32'sh000028BE;
      17: atan_turn = 32'sh0000145F;
      18: atan_turn = 32'sh00000A30;
      19: atan_turn = 32'sh00000518;
      20: atan_turn = 32'sh0000028C;
      21: atan_turn = 32'sh00000146;
      22: atan_turn = 32'sh000000A3;
      23: atan_turn = 32'sh00000051;
      24: atan_turn = 32'sh00000029;
      25: atan_turn = 32'sh00000014;
      26: atan_turn = 32'sh0000000A;
      27: atan_turn = 32'sh00000005;
      28: atan_turn = 32'sh00000003;
      29: atan_turn = 32'sh00000001;
      default: atan_turn = '0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/pumap_angle.sv =====
module pumap_angle
  import pumap_pkg::*;
(
  input  logic                     clk,
  input  logic                     ce,
  input  logic [COL_W-1:0]         col,
  input  logic [WID_W-1:0]         width,
  output logic signed [TRIG_W-1:0] sin_q,
  output logic signed [TRIG_W-1:0] cos_q
);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // round q2.30 to q1.15 and limit
  function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] t;
    logic signed [CW:0] r;
    t = $signed({v[CW-1], v}) + $signed((CW+1)'(16384));
    r = t >>> 15;
    if (r > 32767) to_q15 = 16'sh7FFF;
    else if (r < -32768) to_q15 = 16'sh8000;
    else to_q15 = r[TRIG_W-1:0];
  endfunction

  // restoring divider, one quotient bit a stage
  logic [WID_W-1:0]      srem [0:ADIV_STAGES-1];
  logic [COL_W-1:0]      scol [0:COL_W-1];
  logic [ANGLE_BITS-1:0] sq   [0:ADIV_STAGES];

  assign srem[0] = '0;
  assign scol[0] = col;
  assign sq[0]   = '0;

  for (genvar k = 0; k < ADIV_STAGES; k++) begin : g_div
    logic                  bit_in;
    logic [WID_W:0]        trial;
    logic                  take;
    logic [ANGLE_BITS-1:0] q_r;

    if (k < COL_W) begin : g_bit
      assign bit_in = scol[k][COL_W-1-k];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign trial = {srem[k], bit_in};
    assign take  = trial >= {1'b0, width};

    if (k + 1 < ADIV_STAGES) begin : g_rem
      logic [WID_W-1:0] rem_r;
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r <= take ? WID_W'(trial - {1'b0, width}) : WID_W'(trial);
        end
      end
      assign srem[k+1] = rem_r;
    end

    if (k + 1 < COL_W) begin : g_col
      logic [COL_W-1:0] col_r;
      always_ff @(posedge clk) begin
        if (ce) begin
          col_r <= scol[k];
        end
      end
      assign scol[k+1] = col_r;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        q_r <= {sq[k][ANGLE_BITS-2:0], take};
      end
    end
    assign sq[k+1] = q_r;
  end

  // cordic rotation over the angle within its quadrant
  logic signed [CW-1:0] cx [0:CORDIC_STEPS];
  logic signed [CW-1:0] cy [0:CORDIC_STEPS];
  logic signed [ZW-1:0] cz [0:CORDIC_STEPS-1];
  logic [1:0]           cq [0:CORDIC_STEPS];

  assign cx[0] = CORDIC_X0;
  assign cy[0] = '0;
  assign cz[0] = $signed(ZW'({sq[ADIV_STAGES][ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}}));
  assign cq[0] = sq[ADIV_STAGES][ANGLE_BITS-1:ANGLE_BITS-2];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 dir;
    logic signed [CW-1:0] x_r;
    logic signed [CW-1:0] y_r;
    logic [1:0]           quad_r;

    assign dx  = cy[i] >>> i;
    assign dy  = cx[i] >>> i;
    assign dir = !cz[i][ZW-1];

    always_ff @(posedge clk) begin
      if (ce) begin
        x_r    <= dir ? cx[i] - dx : cx[i] + dx;
        y_r    <= dir ? cy[i] + dy : cy[i] - dy;
        quad_r <= cq[i];
      end
    end
    assign cx[i+1] = x_r;
    assign cy[i+1] = y_r;
    assign cq[i+1] = quad_r;

    if (i + 1 < CORDIC_STEPS) begin : g_z
      logic signed [ZW-1:0] z_r;
      always_ff @(posedge clk) begin
        if (ce) begin
          z_r <= dir ? cz[i] - atan_turn(i) : cz[i] + atan_turn(i);
        end
      end
      assign cz[i+1] = z_r;
    end
  end

  // quadrant fold and rounding
  logic signed [CW-1:0] s_full;
  logic signed [CW-1:0] c_full;

  always_comb begin
    case (cq[CORDIC_STEPS])
      QUAD_0: begin
        c_full = cx[CORDIC_STEPS];
        s_full = cy[CORDIC_STEPS];
      end
      QUAD_1: begin
        c_full = -cy[CORDIC_STEPS];
        s_full = cx[CORDIC_STEPS];
      end
      QUAD_2: begin
        c_full = -cx[CORDIC_STEPS];
        s_full = -cy[CORDIC_STEPS];
      end
      QUAD_3: begin
        c_full = cy[CORDIC_STEPS];
        s_full = -cx[CORDIC_STEPS];
      end
      default: begin
        c_full = cx[CORDIC_STEPS];
        s_full = cy[CORDIC_STEPS];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      sin_q <= to_q15(s_full);
      cos_q <= to_q15(c_full);
    end
  end

endmodule

// ===== hw/rtl/pumap_radius.sv =====
module pumap_radius
  import pumap_pkg::*;
(
  input  logic                    clk,
  input  logic                    ce,
  input  logic [ROW_W-1:0]        row,
  input  logic [REG_W-1:0]        inner,
  input  logic [REG_W-1:0]        outer,
  input  logic [REG_W-1:0]        height,
  output logic signed [RAD_W-1:0] radius
);

  // row times radius span
  logic signed [REG_W:0]  diff;
  logic signed [REG_W:0]  row_s;
  logic signed [PROD_W-1:0] prod_r;

  assign diff  = $signed({1'b0, outer}) - $signed({1'b0, inner});
  assign row_s = $signed({1'b0, row});

  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r <= row_s * diff;
    end
  end

  // sign and magnitude
  logic               neg_r;
  logic [MAG_W-1:0]   mag_r;
  logic [PROD_W-1:0]  mag_full;

  assign mag_full = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  always_ff @(posedge clk) begin
    if (ce) begin
      neg_r <= prod_r[PROD_W-1];
      mag_r <= mag_full[MAG_W-1:0];
    end
  end

  // restoring divider over the scaled magnitude
  logic [REG_W-1:0]  srem [0:RNUM_W];
  logic [MAG_W-1:0]  smag [0:MAG_W-1];
  logic [RNUM_W-1:0] sq   [0:RNUM_W];
  logic              sneg [0:RNUM_W];

  assign srem[0] = '0;
  assign smag[0] = mag_r;
  assign sq[0]   = '0;
  assign sneg[0] = neg_r;

  for (genvar k = 0; k < RNUM_W; k++) begin : g_div
    logic              bit_in;
    logic [REG_W:0]    trial;
    logic              take;
    logic [REG_W-1:0]  rem_r;
    logic [RNUM_W-1:0] q_r;
    logic              neg_s;

    if (k < MAG_W) begin : g_bit
      assign bit_in = smag[k][MAG_W-1-k];
    end else begin : g_zero
      assign bit_in = 1'b0;
    end

    assign trial = {srem[k], bit_in};
    assign take  = trial >= {1'b0, height};

    if (k + 1 < MAG_W) begin : g_mag
      logic [MAG_W-1:0] mag_s;
      always_ff @(posedge clk) begin
        if (ce) begin
          mag_s <= smag[k];
        end
      end
      assign smag[k+1] = mag_s;
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r <= take ? REG_W'(trial - {1'b0, height}) : REG_W'(trial);
        q_r   <= {sq[k][RNUM_W-2:0], take};
        neg_s <= sneg[k];
      end
    end
    assign srem[k+1] = rem_r;
    assign sq[k+1]   = q_r;
    assign sneg[k+1] = neg_s;
  end

  // floor of a negative quotient rounds away from zero
  logic [RAD_W-1:0]        q_ext;
  logic signed [RAD_W-1:0] qs_r;

  assign q_ext = RAD_W'(sq[RNUM_W]);

  always_ff @(posedge clk) begin
    if (ce) begin
      qs_r <= sneg[RNUM_W] ? $signed(~q_ext + RAD_W'(srem[RNUM_W] == '0)) : $signed(q_ext);
    end
  end

  // add the inner radius
  always_ff @(posedge clk) begin
    if (ce) begin
      radius <= qs_r + $signed({{(RAD_W-REG_W-FRAC_BITS){1'b0}}, inner, {FRAC_BITS{1'b0}}});
    end
  end

endmodule

// ===== hw/rtl/polar_unwrap_coordinate_map_unit.sv =====
// Maps each output pixel (row, column) of an unwrapped panorama to its source point in the
// ring-shaped omnidirectional image: radius = inner + row*(outer-inner)/height, angle =
// column/width of a turn, src_x = center_x + r*sin, src_y = center_y + r*cos, both signed
// with 8 fraction bits and saturated to 22 bits. One request is taken every clock cycle;
// each result passes through the 29-stage angle divider, the
// 30-stage cordic and the rounding, multiply and add stages behind them. The
// whole pipeline holds while the result at the output is not taken. Registers sit on an
// apb-style port at byte address 4*i: center_x, center_y, inner_radius, outer_radius,
// out_width, out_height; a zero width or height acts as one. Write them only while idle.
module polar_unwrap_coordinate_map_unit
  import pumap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // out_row[11:0], out_col[24:12], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // src_x[21:0], src_y[43:22], zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [AW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [REG_W-1:0] center_x;
  logic [REG_W-1:0] center_y;
  logic [REG_W-1:0] inner_radius;
  logic [REG_W-1:0] outer_radius;
  logic [WID_W-1:0] out_width;
  logic [REG_W-1:0] out_height;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= REG_W'(1000);
      center_y     <= REG_W'(560);
      inner_radius <= REG_W'(130);
      outer_radius <= REG_W'(280);
      out_width    <= WID_W'(1288);
      out_height   <= REG_W'(150);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[AW-1:2])
        REG_CENTER_X: center_x     <= pwdata[REG_W-1:0];
        REG_CENTER_Y: center_y     <= pwdata[REG_W-1:0];
        REG_INNER:    inner_radius <= pwdata[REG_W-1:0];
        REG_OUTER:    outer_radius <= pwdata[REG_W-1:0];
        REG_WIDTH:    out_width    <= pwdata[WID_W-1:0];
        REG_HEIGHT:   out_height   <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[AW-1:2])
      REG_CENTER_X: prdata = 32'(center_x);
      REG_CENTER_Y: prdata = 32'(center_y);
      REG_INNER:    prdata = 32'(inner_radius);
      REG_OUTER:    prdata = 32'(outer_radius);
      REG_WIDTH:    prdata = 32'(out_width);
      REG_HEIGHT:   prdata = 32'(out_height);
      default:      prdata = '0;
    endcase
  end

  // zero dimensions act as one
  logic [WID_W-1:0] width_eff;
  logic [REG_W-1:0] height_eff;

  assign width_eff  = (out_width == '0) ? WID_W'(1) : out_width;
  assign height_eff = (out_height == '0) ? REG_W'(1) : out_height;

  // pipeline advance and valid bits
  logic                 ce;
  logic [TOTAL_LAT-1:0] vld;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;
  assign m_tvalid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[TOTAL_LAT-2:0], s_tvalid};
    end
  end

  // angle and radius paths
  logic signed [TRIG_W-1:0] sin_q;
  logic signed [TRIG_W-1:0] cos_q;
  logic signed [RAD_W-1:0]  radius;

  pumap_angle u_angle (
    .clk   (clk),
    .ce    (ce),
    .col   (s_tdata[ROW_W +: COL_W]),
    .width (width_eff),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  pumap_radius u_radius (
    .clk    (clk),
    .ce     (ce),
    .row    (s_tdata[ROW_W-1:0]),
    .inner  (inner_radius),
    .outer  (outer_radius),
    .height (height_eff),
    .radius (radius)
  );

  // align radius with the trig results
  logic signed [RAD_W-1:0] rad_dly [0:RAD_DLY-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      rad_dly[0] <= radius;
      for (int i = 1; i < RAD_DLY; i++) begin
        rad_dly[i] <= rad_dly[i-1];
      end
    end
  end

  // radius times sine and cosine
  logic signed [MUL_W-1:0] px;
  logic signed [MUL_W-1:0] py;

  always_ff @(posedge clk) begin
    if (ce) begin
      px <= rad_dly[RAD_DLY-1] * sin_q;
      py <= rad_dly[RAD_DLY-1] * cos_q;
    end
  end

  // round the offsets
  logic signed [MUL_W:0]   px_rnd;
  logic signed [MUL_W:0]   py_rnd;
  logic signed [MUL_W:0]   px_sh;
  logic signed [MUL_W:0]   py_sh;
  logic signed [OFS_W-1:0] ox;
  logic signed [OFS_W-1:0] oy;

  assign px_rnd = $signed({px[MUL_W-1], px}) + $signed((MUL_W+1)'(16384));
  assign py_rnd = $signed({py[MUL_W-1], py}) + $signed((MUL_W+1)'(16384));
  assign px_sh  = px_rnd >>> 15;
  assign py_sh  = py_rnd >>> 15;

  always_ff @(posedge clk) begin
    if (ce) begin
      ox <= px_sh[OFS_W-1:0];
      oy <= py_sh[OFS_W-1:0];
    end
  end

  // add the centre and saturate
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [OUT_W-1:0]        src_x;
  logic [OUT_W-1:0]        src_y;

  assign sum_x = $signed({{(SUM_W-REG_W-FRAC_BITS){1'b0}}, center_x, {FRAC_BITS{1'b0}}})
               + $signed({ox[OFS_W-1], ox});
  assign sum_y = $signed({{(SUM_W-REG_W-FRAC_BITS){1'b0}}, center_y, {FRAC_BITS{1'b0}}})
               + $signed({oy[OFS_W-1], oy});

  always_ff @(posedge clk) begin
    if (ce) begin
      if (sum_x > OUT_MAX) src_x <= OUT_W'(OUT_MAX);
      else if (sum_x < OUT_MIN) src_x <= OUT_W'(OUT_MIN);
      else src_x <= sum_x[OUT_W-1:0];
      if (sum_y > OUT_MAX) src_y <= OUT_W'(OUT_MAX);
      else if (sum_y < OUT_MIN) src_y <= OUT_W'(OUT_MIN);
      else src_y <= sum_y[OUT_W-1:0];
    end
  end

  assign m_tdata = {{(48-2*OUT_W){1'b0}}, src_y, src_x};

endmodule
